[src/dfe_pkg.sv]
`default_nettype none

package dfe_pkg;

  localparam int unsigned MaxFrame   = 64;
  localparam int unsigned MaxTerm    = 8;
  localparam int unsigned StoreDepth = MaxFrame + MaxTerm;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CountW     = $clog2(StoreDepth + 1);
  localparam int unsigned TermLenW   = 4;
  localparam int unsigned MaxLenW    = 7;

  typedef enum logic [1:0] {
    CFG_FRAME_MODE = 2'd0,
    CFG_TERM_LEN   = 2'd1,
    CFG_TERM_BYTES = 2'd2,
    CFG_MAX_BYTES  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FS_PAYLOAD = 2'd0,
    FS_EMPTY   = 2'd1,
    FS_FAIL    = 2'd2
  } frame_status_e;

  typedef enum logic {
    MODE_FIXED = 1'b0,
    MODE_TERM  = 1'b1
  } frame_mode_e;

  typedef struct packed {
    logic          last;
    frame_status_e status;
    logic          from_mem;
  } stage_t;

  // last k received bytes (newest in bits 7:0) equal the first k terminator bytes
  function automatic logic prefix_match(logic [63:0] recent, logic [63:0] term,
                                        logic [TermLenW-1:0] k);
    logic       ok;
    logic [2:0] tidx;
    ok = 1'b1;
    for (int j = 0; j < MaxTerm; j++) begin
      tidx = 3'(k - TermLenW'(j) - TermLenW'(1));
      if (TermLenW'(j) < k) begin
        if (recent[8*j +: 8] != term[8*tidx +: 8]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

[src/delimited_frame_extractor.sv]
// path: a single result (empty frame or failure) goes from stage s1 into the output register,
// a payload frame's bytes are read from the frame store into s1, then into the output register
// throughput: one byte per cycle while collecting a frame with s1 empty; payload bytes stream out
// one per cycle unless the output stalls, limited by the store's single read port, input stalled meanwhile
// reset: async active low, clears config to defaults, count, history and valids;
// the frame store is not cleared and needs no clearing pass
`default_nettype none

module delimited_frame_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // rx_byte [7:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // payload_byte [7:0]
  output logic             m_axis_tlast_o,
  output logic [1:0]       m_axis_tuser_o,  // frame_status [1:0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int unsigned AW = dfe_pkg::AddrW;
  localparam int unsigned CW = dfe_pkg::CountW;
  localparam int unsigned TW = dfe_pkg::TermLenW;
  localparam int unsigned MW = dfe_pkg::MaxLenW;

  // configuration
  dfe_pkg::frame_mode_e mode_q;
  logic [TW-1:0]        term_len_q;
  logic [63:0]          term_bytes_q;
  logic [MW-1:0]        max_bytes_q;

  logic cfg_acc;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= dfe_pkg::MODE_TERM;
      term_len_q   <= TW'(2);
      term_bytes_q <= 64'h0A0D;
      max_bytes_q  <= MW'(dfe_pkg::MaxFrame);
    end else if (cfg_acc) begin
      unique case (dfe_pkg::cfg_idx_e'(cfg_index_i))
        dfe_pkg::CFG_FRAME_MODE: mode_q <= dfe_pkg::frame_mode_e'(cfg_data_i[0]);
        dfe_pkg::CFG_TERM_LEN:   term_len_q <= cfg_data_i[TW-1:0];
        dfe_pkg::CFG_TERM_BYTES: term_bytes_q <= cfg_data_i;
        dfe_pkg::CFG_MAX_BYTES:  max_bytes_q <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  logic [TW-1:0] tl_eff;
  logic [MW-1:0] mx_eff;

  always_comb begin
    tl_eff = term_len_q;
    if (term_len_q == '0) begin
      tl_eff = TW'(1);
    end else if (term_len_q > TW'(dfe_pkg::MaxTerm)) begin
      tl_eff = TW'(dfe_pkg::MaxTerm);
    end
    mx_eff = max_bytes_q;
    if (max_bytes_q == '0) begin
      mx_eff = MW'(1);
    end else if (max_bytes_q > MW'(dfe_pkg::MaxFrame)) begin
      mx_eff = MW'(dfe_pkg::MaxFrame);
    end
  end

  // frame state
  logic [CW-1:0] count_q, count_d;
  logic [63:0]   recent_q, recent_d;

  // emission control
  logic          emit_q, emit_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [AW-1:0] emit_end_q, emit_end_d;

  // stage after the memory read, then the output register
  logic            s1_valid_q, s1_valid_d;
  dfe_pkg::stage_t s1_q, s1_d;
  logic [7:0]      rd_data_q;
  logic            out_valid_q;
  logic [7:0]      out_data_q;
  logic            out_last_q;
  logic [1:0]      out_status_q;

  logic in_acc, adv, rd_en;
  assign s_axis_tready_o = !emit_q && !s1_valid_q;
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign rd_en           = emit_q && (!s1_valid_q || adv);

  // per-item decision
  logic [CW-1:0] count_pre, len, pos, excess;
  logic [63:0]   recent_pre, recent_new;
  logic          do_emit, do_single;
  logic [CW-1:0] emit_n;
  dfe_pkg::frame_status_e single_status;

  always_comb begin
    if (count_q >= CW'(dfe_pkg::StoreDepth)) begin
      count_pre  = '0;
      recent_pre = '0;
    end else begin
      count_pre  = count_q;
      recent_pre = recent_q;
    end
    len           = count_pre + CW'(1);
    recent_new    = {recent_pre[55:0], s_axis_tdata_i};
    pos           = len - CW'(tl_eff);
    excess        = len - CW'(mx_eff);
    do_emit       = 1'b0;
    do_single     = 1'b0;
    emit_n        = CW'(mx_eff);
    single_status = dfe_pkg::FS_FAIL;
    if (mode_q == dfe_pkg::MODE_FIXED) begin
      if (len >= CW'(mx_eff)) begin
        do_emit = 1'b1;
      end
    end else if (len >= CW'(tl_eff)) begin
      if (dfe_pkg::prefix_match(recent_new, term_bytes_q, tl_eff)) begin
        if (pos > CW'(mx_eff)) begin
          do_single = 1'b1;
        end else if (pos == '0) begin
          do_single     = 1'b1;
          single_status = dfe_pkg::FS_EMPTY;
        end else begin
          do_emit = 1'b1;
          emit_n  = pos;
        end
      end else if (len > CW'(mx_eff)) begin
        if (excess > CW'(tl_eff)) begin
          do_single = 1'b1;
        end else if (!dfe_pkg::prefix_match(recent_new, term_bytes_q, excess[TW-1:0])) begin
          do_single = 1'b1;
        end
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    recent_d   = recent_q;
    emit_d     = emit_q;
    rd_addr_d  = rd_addr_q;
    emit_end_d = emit_end_q;
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (s1_valid_q && adv) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      if (do_emit || do_single) begin
        count_d  = '0;
        recent_d = '0;
      end else begin
        count_d  = len;
        recent_d = recent_new;
      end
      if (do_emit) begin
        emit_d     = 1'b1;
        rd_addr_d  = '0;
        emit_end_d = AW'(emit_n - CW'(1));
      end
      if (do_single) begin
        s1_valid_d = 1'b1;
        s1_d       = '{last: 1'b1, status: single_status, from_mem: 1'b0};
      end
    end
    if (rd_en) begin
      s1_valid_d = 1'b1;
      s1_d       = '{last: rd_addr_q == emit_end_q, status: dfe_pkg::FS_PAYLOAD,
                     from_mem: 1'b1};
      rd_addr_d  = rd_addr_q + AW'(1);
      if (rd_addr_q == emit_end_q) begin
        emit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      recent_q    <= '0;
      emit_q      <= 1'b0;
      rd_addr_q   <= '0;
      emit_end_q  <= '0;
      s1_valid_q  <= 1'b0;
      s1_q        <= '{last: 1'b0, status: dfe_pkg::FS_PAYLOAD, from_mem: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      recent_q   <= recent_d;
      emit_q     <= emit_d;
      rd_addr_q  <= rd_addr_d;
      emit_end_q <= emit_end_d;
      s1_valid_q <= s1_valid_d;
      s1_q       <= s1_d;
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_data_q   <= s1_q.from_mem ? rd_data_q : 8'h00;
      out_last_q   <= s1_q.last;
      out_status_q <= s1_q.status;
    end
  end

  // frame store
  logic [7:0] frame_store [dfe_pkg::StoreDepth];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_store[count_pre[AW-1:0]] <= s_axis_tdata_i;
    end
    if (rd_en) begin
      rd_data_q <= frame_store[rd_addr_q];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(dfe_pkg::StoreDepth))
    else $error("byte count beyond store depth");

  a_read_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> rd_addr_q <= emit_end_q)
    else $error("read past end of frame");

  a_emit_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && do_emit |=> emit_q && rd_addr_q == '0)
    else $error("frame emission did not start");

  a_single_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != dfe_pkg::FS_PAYLOAD |->
      m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("empty or failure item malformed");

endmodule

`default_nettype wire

[bench/testbench.sv]
module testbench;
  import dfe_pkg::*;

  typedef struct packed {
    logic [7:0]    payload_byte;
    logic          frame_end;
    frame_status_e frame_status;
  } frame_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data;
  logic        out_last;
  logic [1:0]  out_user;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_e    cfg_index = CFG_FRAME_MODE;
  logic [63:0] cfg_data = '0;

  delimited_frame_extractor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (rx_valid),
    .s_axis_tready_o (rx_ready),
    .s_axis_tdata_i  (rx_data),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tlast_o  (out_last),
    .m_axis_tuser_o  (out_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // predictor state and register copies
  frame_mode_e mode_q = MODE_TERM;
  logic [3:0]  term_len_q = 4'd2;
  logic [63:0] term_q = 64'h0A0D;
  logic [6:0]  max_q = 7'd64;
  logic [7:0]  frame_bytes [StoreDepth];
  int unsigned held_cnt = 0;
  logic [63:0] history_q = '0;

  logic [7:0]  rx_q[$];
  frame_out_t  frames_due[$];
  frame_out_t  head;
  int unsigned queued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned rx_gap = 0;
  int unsigned out_stall = 0;
  bit          quiet = 1'b0;
  int          errors = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] term_at(int unsigned i);
    return term_q[8*(i & 7) +: 8];
  endfunction

  task automatic emit_payload(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      frames_due.push_back('{payload_byte: frame_bytes[i], frame_end: (i + 1 == n),
                             frame_status: FS_PAYLOAD});
    end
    held_cnt = 0;
    history_q = '0;
  endtask

  task automatic emit_single(frame_status_e st);
    frames_due.push_back('{payload_byte: 8'h00, frame_end: 1'b1, frame_status: st});
    held_cnt = 0;
    history_q = '0;
  endtask

  task automatic extract_byte(logic [7:0] b);
    int unsigned mx, tl, len, pos;
    bit hit, bad;
    mx = (max_q == 0) ? 1 : (max_q > MaxFrame) ? MaxFrame : max_q;
    tl = (term_len_q == 0) ? 1 : (term_len_q > MaxTerm) ? MaxTerm : term_len_q;
    if (held_cnt >= StoreDepth) begin
      held_cnt = 0;
      history_q = '0;
    end
    frame_bytes[held_cnt] = b;
    held_cnt++;
    history_q = {history_q[55:0], b};
    len = held_cnt;
    if (mode_q == MODE_FIXED) begin
      if (len >= mx) emit_payload(mx);
    end else if (len >= tl) begin
      hit = 1'b1;
      for (int unsigned i = 0; i < tl; i++) begin
        if (history_q[8*(tl-1-i) +: 8] != term_at(i)) hit = 1'b0;
      end
      pos = len - tl;
      if (hit) begin
        if (pos > mx) emit_single(FS_FAIL);
        else if (pos == 0) emit_single(FS_EMPTY);
        else emit_payload(pos);
      end else if (len > mx) begin
        bad = (len > mx + tl);
        for (int unsigned i = mx; i < len && !bad; i++) begin
          if (frame_bytes[i] != term_at(i - mx)) bad = 1'b1;
        end
        if (bad) emit_single(FS_FAIL);
      end
    end
  endtask

  // input side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_valid <= 1'b0;
    end else begin
      if (rx_valid && rx_ready) begin
        extract_byte(rx_data);
        taken_cnt++;
      end
      if (!rx_valid || rx_ready) begin
        if (rx_gap > 0) begin
          rx_gap--;
          rx_valid <= 1'b0;
        end else if (rx_q.size() > 0) begin
          rx_data <= rx_q.pop_front();
          rx_valid <= 1'b1;
          rx_gap = quiet ? 0 : pick_gap();
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected item: payload_byte %0h frame_end %0d frame_status %0d",
                 out_data, out_last, out_user);
          errors++;
        end else begin
          head = frames_due.pop_front();
          if (out_data !== head.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", head.payload_byte, out_data);
            errors++;
          end
          if (out_last !== head.frame_end) begin
            $error("frame_end: expected %0d, got %0d", head.frame_end, out_last);
            errors++;
          end
          if (out_user !== head.frame_status) begin
            $error("frame_status: expected %0d, got %0d", head.frame_status, out_user);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_stall = pick_gap();
      end
    end
  end

  task automatic push_byte(logic [7:0] b);
    rx_q.push_back(b);
    queued_cnt++;
  endtask

  task automatic drain();
    while (queued_cnt != taken_cnt || frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_FRAME_MODE: mode_q = frame_mode_e'(val[0]);
      CFG_TERM_LEN:   term_len_q = val[3:0];
      CFG_TERM_BYTES: term_q = val;
      CFG_MAX_BYTES:  max_q = val[6:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned kind, tle, mx, eff, nfr, r, len, k;
    logic [3:0]  tl;
    logic [63:0] word;
    logic [7:0]  fill;
    frame_mode_e md;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty frame, then both byte extremes under the default terminator
    push_byte(8'h0D);
    push_byte(8'h0A);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h0D);
    push_byte(8'h0A);
    drain();
    // zero max acts as one
    set_reg(CFG_FRAME_MODE, 64'(MODE_FIXED));
    set_reg(CFG_MAX_BYTES, 64'd0);
    push_byte(8'h5A);
    push_byte(8'hA5);
    drain();
    // fixed frame shrunk mid-frame: first bytes out, rest dropped
    set_reg(CFG_MAX_BYTES, 64'd4);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    drain();
    set_reg(CFG_MAX_BYTES, 64'd2);
    push_byte(8'h44);
    drain();
    // zero terminator length acts as one
    set_reg(CFG_FRAME_MODE, 64'(MODE_TERM));
    set_reg(CFG_TERM_LEN, 64'd0);
    set_reg(CFG_TERM_BYTES, 64'd0);
    set_reg(CFG_MAX_BYTES, 64'd8);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h00);
    push_byte(8'h00);
    drain();
    // terminator found past the limit after the limit shrinks
    set_reg(CFG_TERM_LEN, 64'd1);
    set_reg(CFG_TERM_BYTES, 64'h5A);
    for (int i = 1; i <= 5; i++) push_byte(8'(i));
    drain();
    set_reg(CFG_MAX_BYTES, 64'd2);
    push_byte(8'h5A);
    drain();
    // excess byte not matching the terminator
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    drain();

    for (int ph = 0; queued_cnt < 300; ph++) begin
      kind = (ph < 6) ? ph : $urandom_range(0, 5);
      quiet = ($urandom_range(0, 3) == 0);
      md = MODE_TERM;
      tl = 4'($urandom_range(1, 8));
      word = {$urandom, $urandom};
      case (kind)
        0: begin
          tl = 4'd2;
          word = 64'h0A0D;
          mx = 64;
        end
        1: begin
          tl = 4'd1;
          mx = $urandom_range(1, 16);
        end
        2: begin
          tl = 4'($urandom_range(2, 8));
          mx = $urandom_range(tl, 20);
        end
        3: begin
          tl = ($urandom_range(0, 1) == 1) ? 4'd15 : 4'd8;
          fill = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom);
          word = {8{fill}};
          mx = 8;
        end
        4: begin
          md = MODE_FIXED;
          mx = $urandom_range(1, 8);
        end
        default: begin
          md = MODE_FIXED;
          mx = ($urandom_range(0, 1) == 1) ? 64 : 127;
        end
      endcase
      set_reg(CFG_FRAME_MODE, 64'(md));
      set_reg(CFG_TERM_LEN, 64'(tl));
      set_reg(CFG_TERM_BYTES, word);
      set_reg(CFG_MAX_BYTES, 64'(mx));
      tle = (tl > MaxTerm) ? MaxTerm : tl;
      eff = (mx > MaxFrame) ? MaxFrame : mx;
      if (md == MODE_FIXED) begin
        nfr = (eff >= 32) ? 1 : $urandom_range(2, 5);
        repeat (nfr * eff) push_byte(8'($urandom));
      end else begin
        nfr = $urandom_range(3, 7);
        repeat (nfr) begin
          r = $urandom_range(0, 9);
          if (r < 7) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, eff)
                                              : $urandom_range(0, (eff < 6) ? eff : 6);
            repeat (len) begin
              if (tle > 1 && $urandom_range(0, 7) == 0) begin
                k = $urandom_range(1, tle - 1);
                for (int i = 0; i < k; i++) push_byte(term_at(i));
              end else begin
                push_byte(8'($urandom));
              end
            end
            for (int i = 0; i < tle; i++) push_byte(term_at(i));
          end else if (r < 9) begin
            // overrun whose excess starts like the terminator
            repeat (eff) push_byte(8'($urandom));
            k = $urandom_range(0, tle - 1);
            for (int i = 0; i < k; i++) push_byte(term_at(i));
            push_byte(8'($urandom));
          end else begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
          end
        end
      end
      drain();
    end

    quiet = 1'b0;
    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
